// File: rtl/core/plar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plar_pkg: shared types and constants of the polyline resampler
// Holds the job descriptor between front and back and the register set.
// ----------------------------------------------------------------------------
package plar_pkg;

    localparam int LEN_W   = 28;   // arc length width
    localparam int CNT_W   = 7;    // vertex count, holds up to 127
    localparam int FIELD_W = 20;   // coordinate field width on the ports

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // register indexes on the configuration port
    localparam logic [2:0] REG_DESIRED_STEP     = 3'd0;
    localparam logic [2:0] REG_COARSE_START     = 3'd1;
    localparam logic [2:0] REG_VIABILITY_MODE   = 3'd2;
    localparam logic [2:0] REG_MIN_FINAL_LENGTH = 3'd3;
    localparam logic [2:0] REG_GROUPING_LENGTH  = 3'd4;
    localparam logic [2:0] REG_MIN_VERTEX_COUNT = 3'd5;

    // viability test selection; any other code means the final length test
    localparam logic [1:0] MODE_COUNT    = 2'd0;
    localparam logic [1:0] MODE_GROUPING = 2'd1;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [LEN_W-1:0] len;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_q;

    typedef struct packed {
        logic [12:0] desired_step;
        logic        coarse_start;
        logic [1:0]  viability_mode;
        logic [19:0] min_final_length;
        logic [19:0] grouping_length;
        logic [6:0]  min_vertex_count;
    } t_cfg;

endpackage
`default_nettype wire

// File: rtl/core/plar_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plar_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module plar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/core/plar_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plar_div: restoring divider, one quotient bit per cycle
// Requires the numerator shifted right by QW to be below the divisor.
// ----------------------------------------------------------------------------
module plar_div #(
    parameter int NW = 55,
    parameter int DW = 34,
    parameter int QW = 28
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);

    localparam int CB = $clog2(QW + 1);

    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den, n_den;
    logic [QW-1:0] r_quo, n_quo;
    logic [CB-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [DW:0]   trial;
    logic          ge;

    always_comb begin
        trial  = {r_rem[DW-1:0], r_quo[QW-1]};
        ge     = trial >= {1'b0, r_den};
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = (DW+1)'(i_num >> QW);
            n_den  = i_den;
            n_quo  = i_num[QW-1:0];
            n_cnt  = CB'(QW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? (trial - {1'b0, r_den}) : trial;
            n_quo = {r_quo[QW-2:0], ge};
            n_cnt = r_cnt - CB'(1);
            if (r_cnt == CB'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[DW-1:0];

endmodule
`default_nettype wire

// File: rtl/core/plar_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plar_front: vertex loader
// Accumulate segment lengths with an iterative square root, fill the stores
// and queue one job per polyline.
// ----------------------------------------------------------------------------
module plar_front #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_W      = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [plar_pkg::FIELD_W-1:0]  i_px,
    input  logic [plar_pkg::FIELD_W-1:0]  i_py,
    input  logic [plar_pkg::FIELD_W-1:0]  i_pz,
    input  logic                          i_eol,
    output logic                          o_we,
    output logic [$clog2(MAX_VERTICES):0] o_waddr,
    output logic [3*COORD_W-1:0]          o_wvert,
    output logic [plar_pkg::LEN_W-1:0]    o_warc,
    output plar_pkg::t_job_q              o_job,
    input  logic                          i_pop
);

    localparam int IW   = $clog2(MAX_VERTICES);
    localparam int RW   = COORD_W + 1;
    localparam int SW   = 2 * RW;
    localparam int ITB  = $clog2(RW + 1);
    localparam int SUMW = ((plar_pkg::LEN_W > RW + 1) ? plar_pkg::LEN_W : RW + 1) + 1;
    localparam int LW   = plar_pkg::LEN_W;
    localparam int NCW  = plar_pkg::CNT_W;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_SQ   = 4'b0010,
        F_ROOT = 4'b0100,
        F_FIN  = 4'b1000
    } t_fstate;

    t_fstate          r_state, n_state;
    logic [NCW-1:0]   r_cnt, n_cnt;
    logic [LW-1:0]    r_len, n_len;
    logic             r_bank, n_bank;
    logic [COORD_W-1:0] r_p [3];
    logic [COORD_W-1:0] r_prev [3];
    logic             r_eol;
    logic [SW-1:0]    r_sum, n_sum;
    logic [1:0]       r_c, n_c;
    logic [RW-1:0]    r_root, n_root;
    logic [RW+1:0]    r_srem, n_srem;
    logic [SW-1:0]    r_srad, n_srad;
    logic [ITB-1:0]   r_it, n_it;
    plar_pkg::t_job   r_qjob [2];
    logic             r_qhead, n_qhead;
    logic [1:0]       r_qcnt, n_qcnt;

    logic             accept, push, in_room;
    logic [COORD_W-1:0] pa, pb, d;
    logic [2*COORD_W-1:0] sq;
    logic [RW+1:0]    rem_t, trial;
    logic [RW:0]      seg;
    logic [SUMW-1:0]  acc;
    logic [LW-1:0]    new_len;
    plar_pkg::t_job   push_job;

    assign o_ready = (r_state == F_IDLE) && (r_qcnt != 2'd2);
    assign accept  = i_valid && o_ready;
    assign in_room = r_cnt < NCW'(MAX_VERTICES);

    always_comb begin
        pa    = r_p[r_c];
        pb    = r_prev[r_c];
        d     = (pa > pb) ? (pa - pb) : (pb - pa);
        sq    = d * d;
        rem_t = {r_srem[RW-1:0], r_srad[SW-1:SW-2]};
        trial = {r_root, 2'b01};
        seg   = {1'b0, r_root} + (RW+1)'(r_srem > (RW+2)'(r_root));
        acc   = SUMW'(r_len) + SUMW'(seg);
        if (r_cnt == '0) begin
            new_len = '0;
        end else if (acc > SUMW'(plar_pkg::LEN_MAX)) begin
            new_len = plar_pkg::LEN_MAX;
        end else begin
            new_len = acc[LW-1:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_bank   = r_bank;
        n_sum    = r_sum;
        n_c      = r_c;
        n_root   = r_root;
        n_srem   = r_srem;
        n_srad   = r_srad;
        n_it     = r_it;
        push     = 1'b0;
        push_job = '{n: r_cnt, len: r_len};
        o_we     = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_sum = '0;
                    n_c   = 2'd0;
                    if (r_cnt == '0 || !in_room) begin
                        n_state = F_FIN;
                    end else begin
                        n_state = F_SQ;
                    end
                end
            end
            F_SQ: begin
                n_sum = r_sum + SW'(sq);
                n_c   = r_c + 2'd1;
                if (r_c == 2'd2) begin
                    n_srad  = n_sum;
                    n_srem  = '0;
                    n_root  = '0;
                    n_it    = ITB'(RW);
                    n_state = F_ROOT;
                end
            end
            F_ROOT: begin
                // one root bit per cycle, remainder kept for rounding
                if (rem_t >= trial) begin
                    n_srem = rem_t - trial;
                    n_root = {r_root[RW-2:0], 1'b1};
                end else begin
                    n_srem = rem_t;
                    n_root = {r_root[RW-2:0], 1'b0};
                end
                n_srad = {r_srad[SW-3:0], 2'b00};
                n_it   = r_it - ITB'(1);
                if (r_it == ITB'(1)) begin
                    n_state = F_FIN;
                end
            end
            F_FIN: begin
                if (in_room) begin
                    o_we  = 1'b1;
                    n_cnt = r_cnt + NCW'(1);
                    n_len = new_len;
                end
                if (r_eol) begin
                    push     = 1'b1;
                    push_job = '{n: n_cnt, len: n_len};
                    n_cnt    = '0;
                    n_len    = '0;
                    n_bank   = ~r_bank;
                end
                n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        n_qhead = r_qhead;
        n_qcnt  = r_qcnt;
        if (i_pop) begin
            n_qhead = ~r_qhead;
        end
        case ({push, i_pop})
            2'b10:   n_qcnt = r_qcnt + 2'd1;
            2'b01:   n_qcnt = r_qcnt - 2'd1;
            default: n_qcnt = r_qcnt;
        endcase
    end

    assign o_waddr = {r_bank, r_cnt[IW-1:0]};
    assign o_wvert = {r_p[2], r_p[1], r_p[0]};
    assign o_warc  = new_len;
    assign o_job   = '{valid: (r_qcnt != 2'd0), job: r_qjob[r_qhead]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
            r_len   <= '0;
            r_bank  <= 1'b0;
            r_qhead <= 1'b0;
            r_qcnt  <= 2'd0;
            r_it    <= '0;
            r_c     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_bank  <= n_bank;
            r_qhead <= n_qhead;
            r_qcnt  <= n_qcnt;
            r_it    <= n_it;
            r_c     <= n_c;
        end
        r_sum  <= n_sum;
        r_root <= n_root;
        r_srem <= n_srem;
        r_srad <= n_srad;
        if (accept) begin
            r_p[0] <= COORD_W'(i_px);
            r_p[1] <= COORD_W'(i_py);
            r_p[2] <= COORD_W'(i_pz);
            r_eol  <= i_eol;
        end
        if (o_we) begin
            r_prev[0] <= r_p[0];
            r_prev[1] <= r_p[1];
            r_prev[2] <= r_p[2];
        end
        if (push) begin
            r_qjob[r_qhead ^ r_qcnt[0]] <= push_job;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/plar_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plar_back: resampling sequencer
// Take one job, work out count and viability, then walk the stores and
// interpolate each output vertex with the shared divider.
// ----------------------------------------------------------------------------
module plar_back #(
    parameter int MAX_VERTICES    = 64,
    parameter int COORD_W         = 20,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  plar_pkg::t_cfg                i_cfg,
    input  plar_pkg::t_job_q              i_job,
    output logic                          o_pop,
    output logic [$clog2(MAX_VERTICES):0] o_raddr,
    input  logic [3*COORD_W-1:0]          i_rvert,
    input  logic [plar_pkg::LEN_W-1:0]    i_rarc,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [plar_pkg::FIELD_W-1:0]  o_qx,
    output logic [plar_pkg::FIELD_W-1:0]  o_qy,
    output logic [plar_pkg::FIELD_W-1:0]  o_qz,
    output logic                          o_viable,
    output logic                          o_truncated,
    output logic                          o_last
);

    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int LW  = plar_pkg::LEN_W;
    localparam int NCW = plar_pkg::CNT_W;
    localparam int FW  = plar_pkg::FIELD_W;
    localparam int PW  = LW + IW;
    localparam int QW  = (LW > COORD_W + 1) ? LW : COORD_W + 1;
    localparam int NW  = COORD_W + PW + 1;
    localparam int SZW = QW + 2;
    localparam logic [PW-1:0] COARSE_STEP = PW'(1) << (COORD_FRAC_BITS - 2);

    typedef enum logic [14:0] {
        B_IDLE = 15'b000000000000001,
        B_QST  = 15'b000000000000010,
        B_DIVQ = 15'b000000000000100,
        B_RDV  = 15'b000000000001000,
        B_LDV  = 15'b000000000010000,
        B_OUT  = 15'b000000000100000,
        B_NEXT = 15'b000000001000000,
        B_SRD  = 15'b000000010000000,
        B_SMUL = 15'b000000100000000,
        B_SCMP = 15'b000001000000000,
        B_L0   = 15'b000010000000000,
        B_L1   = 15'b000100000000000,
        B_MUL  = 15'b001000000000000,
        B_NUM  = 15'b010000000000000,
        B_CPRD = 15'b100000000000000
    } t_bstate;

    // the interpolation divide reuses B_QST/B_DIVQ style handshakes below
    t_bstate          r_state, n_state;
    logic             r_cdiv, n_cdiv;     // divider busy on a coordinate
    logic             r_cst, n_cst;       // start pulse for a coordinate
    logic             r_bank;
    logic [NCW-1:0]   r_n;
    logic [LW-1:0]    r_len;
    logic [PW-1:0]    r_step;
    logic [IW-1:0]    r_m, r_i, r_j, r_vidx;
    logic             r_via, r_tr, r_lastf;
    logic [PW-1:0]    r_target, r_prod, r_a0m, r_den, r_num;
    logic [LW-1:0]    r_a0, r_a1;
    logic [COORD_W-1:0] r_v0 [3];
    logic [COORD_W-1:0] r_v1 [3];
    logic [COORD_W-1:0] r_res [3];
    logic [1:0]       r_c;
    logic [NW-1:0]    r_mprod;
    logic             r_ovalid;
    logic [FW-1:0]    r_oq [3];
    logic             r_oviable, r_otr, r_olast;

    logic [COORD_W-1:0] vrd [3];
    logic [PW-1:0]    n_step;
    logic             div_start, div_done;
    logic [NW-1:0]    div_num;
    logic [PW-1:0]    div_den;
    logic [QW-1:0]    div_quo;
    logic [PW-1:0]    div_rem;
    logic [SZW-1:0]   size;
    logic             rnd, sat, via, out_free, load_out, up;
    logic [COORD_W-1:0] va, vb, mag;
    logic [IW-1:0]    i_nxt;
    logic [IW-1:0]    raddr;

    assign vrd[0] = i_rvert[COORD_W-1:0];
    assign vrd[1] = i_rvert[2*COORD_W-1:COORD_W];
    assign vrd[2] = i_rvert[3*COORD_W-1:2*COORD_W];

    assign out_free = !r_ovalid || i_ready;
    assign load_out = (r_state == B_OUT) && out_free;
    assign o_pop    = load_out && r_lastf;

    always_comb begin
        n_step = i_cfg.coarse_start ? COARSE_STEP : PW'(i_cfg.desired_step);
        if (n_step == '0) begin
            n_step = PW'(1);
        end
        // count = rounded len/step plus one, capped at the store depth
        rnd  = {div_rem, 1'b0} > {1'b0, r_step};
        size = SZW'(div_quo) + SZW'(rnd) + SZW'(1);
        sat  = size > SZW'(MAX_VERTICES);
        if (sat) begin
            size = SZW'(MAX_VERTICES);
        end
        case (i_cfg.viability_mode)
            plar_pkg::MODE_COUNT:    via = NCW'(size) >= i_cfg.min_vertex_count;
            plar_pkg::MODE_GROUPING: via = r_len > LW'(i_cfg.grouping_length);
            default:                 via = r_len > LW'(i_cfg.min_final_length);
        endcase
        va    = r_v0[r_c];
        vb    = r_v1[r_c];
        up    = vb >= va;
        mag   = up ? (vb - va) : (va - vb);
        i_nxt = r_i + IW'(1);
        case (r_state)
            B_RDV:   raddr = r_vidx;
            B_SCMP:  raddr = r_j - IW'(1);
            default: raddr = r_j;
        endcase
        div_start = (r_state == B_QST) || r_cst;
        div_num   = (r_state == B_QST) ? NW'(r_len) : (r_mprod + NW'(r_den >> 1));
        div_den   = (r_state == B_QST) ? r_step : r_den;
    end

    assign o_raddr = {r_bank, raddr};

    plar_div #(
        .NW (NW),
        .DW (PW),
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_comb begin
        n_state = r_state;
        n_cdiv  = r_cdiv;
        n_cst   = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_job.valid) begin
                    if (i_job.job.n < NCW'(2) || PW'(i_job.job.len) < n_step) begin
                        n_state = B_OUT;
                    end else begin
                        n_state = B_QST;
                    end
                end
            end
            B_QST:  n_state = B_DIVQ;
            B_DIVQ: if (div_done) n_state = B_RDV;
            B_RDV:  n_state = B_LDV;
            B_LDV:  n_state = B_OUT;
            B_OUT: begin
                if (out_free) begin
                    n_state = r_lastf ? B_IDLE : B_NEXT;
                end
            end
            B_NEXT: n_state = (i_nxt == r_m) ? B_RDV : B_SRD;
            B_SRD:  n_state = B_SMUL;
            B_SMUL: n_state = B_SCMP;
            B_SCMP: begin
                if (NCW'(r_j) < r_n - NCW'(1) && r_prod < r_target) begin
                    n_state = B_SRD;
                end else begin
                    n_state = B_L0;
                end
            end
            B_L0:   n_state = B_L1;
            B_L1:   n_state = B_MUL;
            B_MUL:  n_state = B_NUM;
            B_NUM:  n_state = B_CPRD;
            B_CPRD: begin
                // multiply, then start the divide and wait for its result
                if (!r_cdiv) begin
                    n_cdiv = 1'b1;
                    n_cst  = 1'b1;
                end else if (div_done) begin
                    n_cdiv = 1'b0;
                    if (r_c == 2'd2) begin
                        n_state = B_OUT;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_cdiv   <= 1'b0;
            r_cst    <= 1'b0;
            r_bank   <= 1'b0;
            r_ovalid <= 1'b0;
            r_lastf  <= 1'b0;
            r_c      <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cdiv  <= n_cdiv;
            r_cst   <= n_cst;
            if (o_pop) begin
                r_bank <= ~r_bank;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_job.valid) begin
                        r_lastf <= (i_job.job.n < NCW'(2)) ||
                                   (PW'(i_job.job.len) < n_step);
                    end
                end
                B_DIVQ:  if (div_done) r_lastf <= 1'b0;
                B_NEXT:  if (i_nxt == r_m) r_lastf <= 1'b1;
                B_NUM:   r_c <= 2'd0;
                B_CPRD: begin
                    if (r_cdiv && div_done) begin
                        r_c <= r_c + 2'd1;
                    end
                end
                default: r_lastf <= r_lastf;
            endcase
        end

        if (load_out) begin
            r_oq[0]   <= FW'(r_res[0]);
            r_oq[1]   <= FW'(r_res[1]);
            r_oq[2]   <= FW'(r_res[2]);
            r_oviable <= r_via;
            r_otr     <= r_tr;
            r_olast   <= r_lastf;
        end

        case (r_state)
            B_IDLE: begin
                r_n    <= i_job.job.n;
                r_len  <= i_job.job.len;
                r_step <= n_step;
                r_via  <= 1'b0;
                r_tr   <= 1'b0;
                r_res[0] <= '0;
                r_res[1] <= '0;
                r_res[2] <= '0;
            end
            B_DIVQ: begin
                if (div_done) begin
                    r_m      <= IW'(size - SZW'(1));
                    r_tr     <= sat;
                    r_via    <= via;
                    r_vidx   <= '0;
                    r_i      <= '0;
                    r_j      <= IW'(1);
                    r_target <= '0;
                end
            end
            B_LDV: begin
                r_res[0] <= vrd[0];
                r_res[1] <= vrd[1];
                r_res[2] <= vrd[2];
            end
            B_NEXT: begin
                r_i      <= i_nxt;
                r_target <= r_target + PW'(r_len);
                r_vidx   <= IW'(r_n - NCW'(1));
            end
            B_SMUL: begin
                r_a1   <= i_rarc;
                r_prod <= PW'(i_rarc) * PW'(r_m);
            end
            B_SCMP: begin
                if (NCW'(r_j) < r_n - NCW'(1) && r_prod < r_target) begin
                    r_j <= r_j + IW'(1);
                end
            end
            B_L0: begin
                r_a0    <= i_rarc;
                r_v0[0] <= vrd[0];
                r_v0[1] <= vrd[1];
                r_v0[2] <= vrd[2];
            end
            B_L1: begin
                r_v1[0] <= vrd[0];
                r_v1[1] <= vrd[1];
                r_v1[2] <= vrd[2];
            end
            B_MUL: begin
                r_a0m <= PW'(r_a0) * PW'(r_m);
                r_den <= PW'(r_a1 - r_a0) * PW'(r_m);
            end
            B_NUM: begin
                r_num <= r_target - r_a0m;
                if (r_den == '0) begin
                    r_den <= PW'(1);
                end
            end
            B_CPRD: begin
                if (!r_cdiv) begin
                    r_mprod <= NW'(mag) * NW'(r_num);
                end else if (div_done) begin
                    r_res[r_c] <= up ? (va + COORD_W'(div_quo)) : (va - COORD_W'(div_quo));
                end
            end
            default: r_m <= r_m;
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_qx        = r_oq[0];
    assign o_qy        = r_oq[1];
    assign o_qz        = r_oq[2];
    assign o_viable    = r_oviable;
    assign o_truncated = r_otr;
    assign o_last      = r_olast;

endmodule
`default_nettype wire

// File: rtl/core/polyline_arc_length_resample.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_arc_length_resample: uniform arc length resampler for 3D polylines
//
// Feed vertices on the s_axis channel, one item per vertex, x/y/z in tdata
// and tlast on the closing vertex of a polyline. Each closing vertex starts
// a resampling run whose items leave on m_axis: x/y/z in tdata, viable and
// truncated in tuser, tlast on the final item of the run. A run of fewer
// than two vertices or shorter than one step gives a single zero item.
//
// Loading a vertex is set by the bit-serial square root of the segment
// length; the first vertex of a line and a vertex dropped on a full store
// skip the root. s_axis_tready is high only while the loader waits for a
// vertex, and stays low while both banks hold lines that wait for the
// resampler. From taking a job to loading the first item the resampler is
// busy mostly with the count divide; each inner item takes three coordinate
// divides on the shared one-bit-per-cycle divider, whose quotient width QW
// is the larger of 28 and COORD_W+1, plus a search step for each stored
// vertex passed. The closing item needs no divide: it is the last stored
// vertex, read from the store. The output register holds an item while
// m_axis_tready is low and the sequencer stalls behind it. Reset empties
// the job queue, clears counts and restores the register defaults.
// ----------------------------------------------------------------------------
module polyline_arc_length_resample #(
    parameter int MAX_VERTICES    = 64,
    parameter int COORD_INT_BITS  = 12,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // vertex input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // px[19:0], py[39:20], pz[59:40], zero
    input  logic        s_axis_tlast,   // end_of_line
    // resampled output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // qx[19:0], qy[39:20], qz[59:40], zero
    output logic [1:0]  m_axis_tuser,   // viable[0], truncated[1]
    output logic        m_axis_tlast,   // last_out
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COORD_W = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int AW      = $clog2(MAX_VERTICES) + 1;
    localparam int LW      = plar_pkg::LEN_W;
    localparam int FW      = plar_pkg::FIELD_W;

    plar_pkg::t_cfg   r_cfg;
    plar_pkg::t_job_q job;
    logic             pop;
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [3*COORD_W-1:0] wvert, rvert;
    logic [LW-1:0]    warc, rarc;
    logic [FW-1:0]    qx, qy, qz;
    logic             viable, truncated;
    logic [2:0]       reg_idx;
    logic             cfg_wr;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{desired_step: 13'd256, coarse_start: 1'b0,
                       viability_mode: plar_pkg::MODE_COUNT,
                       min_final_length: 20'd2560, grouping_length: 20'd1024,
                       min_vertex_count: 7'd3};
        end else if (cfg_wr) begin
            case (reg_idx)
                plar_pkg::REG_DESIRED_STEP:     r_cfg.desired_step     <= pwdata[12:0];
                plar_pkg::REG_COARSE_START:     r_cfg.coarse_start     <= pwdata[0];
                plar_pkg::REG_VIABILITY_MODE:   r_cfg.viability_mode   <= pwdata[1:0];
                plar_pkg::REG_MIN_FINAL_LENGTH: r_cfg.min_final_length <= pwdata[19:0];
                plar_pkg::REG_GROUPING_LENGTH:  r_cfg.grouping_length  <= pwdata[19:0];
                plar_pkg::REG_MIN_VERTEX_COUNT: r_cfg.min_vertex_count <= pwdata[6:0];
                default: ;  // drop writes outside the register list
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            plar_pkg::REG_DESIRED_STEP:     prdata = 32'(r_cfg.desired_step);
            plar_pkg::REG_COARSE_START:     prdata = 32'(r_cfg.coarse_start);
            plar_pkg::REG_VIABILITY_MODE:   prdata = 32'(r_cfg.viability_mode);
            plar_pkg::REG_MIN_FINAL_LENGTH: prdata = 32'(r_cfg.min_final_length);
            plar_pkg::REG_GROUPING_LENGTH:  prdata = 32'(r_cfg.grouping_length);
            plar_pkg::REG_MIN_VERTEX_COUNT: prdata = 32'(r_cfg.min_vertex_count);
            default:                        prdata = 32'd0;
        endcase
    end

    // ---------------- front: load vertices, measure length ----------------
    plar_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_W      (COORD_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_px    (s_axis_tdata[19:0]),
        .i_py    (s_axis_tdata[39:20]),
        .i_pz    (s_axis_tdata[59:40]),
        .i_eol   (s_axis_tlast),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wvert (wvert),
        .o_warc  (warc),
        .o_job   (job),
        .i_pop   (pop)
    );

    // ---------------- stores, two banks of MAX_VERTICES ----------------
    plar_ram #(
        .WIDTH (3 * COORD_W),
        .DEPTH (2 ** AW)
    ) u_vert_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wvert),
        .i_raddr (raddr),
        .o_rdata (rvert)
    );

    plar_ram #(
        .WIDTH (LW),
        .DEPTH (2 ** AW)
    ) u_arc_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (warc),
        .i_raddr (raddr),
        .o_rdata (rarc)
    );

    // ---------------- back: resample and emit ----------------
    plar_back #(
        .MAX_VERTICES    (MAX_VERTICES),
        .COORD_W         (COORD_W),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (job),
        .o_pop       (pop),
        .o_raddr     (raddr),
        .i_rvert     (rvert),
        .i_rarc      (rarc),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_qx        (qx),
        .o_qy        (qy),
        .o_qz        (qz),
        .o_viable    (viable),
        .o_truncated (truncated),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, qz, qy, qx};
    assign m_axis_tuser = {truncated, viable};

endmodule
`default_nettype wire

// File: dv/tb_polyline_arc_length_resample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_arc_length_resample: self-checking bench for the resampler
// Streams 3D polylines into the block under several register settings and
// compares every resampled vertex against an in-bench arc length model.
// ----------------------------------------------------------------------------
module tb_polyline_arc_length_resample;

    localparam int MAX_VTX   = 64;
    localparam int WDOG_MAX  = 20000;  // cycles with no item moving on either side
    localparam int SETTLE    = 200;    // quiet cycles before a register write
    localparam int PHASE_VTX = 35;     // vertex quota of one random phase
    localparam logic [19:0] FMAX = 20'hFFFFF;

    typedef struct {
        logic [plar_pkg::FIELD_W-1:0] qx;
        logic [plar_pkg::FIELD_W-1:0] qy;
        logic [plar_pkg::FIELD_W-1:0] qz;
        logic                         viable;
        logic                         truncated;
        logic                         last_out;
    } t_resample_pt;

    // directed row; zero_run marks rows whose result is the plain zero item
    typedef struct {
        logic [19:0] x;
        logic [19:0] y;
        logic [19:0] z;
        logic        eol;
        logic        zero_run;
    } t_vertex_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // px[19:0], py[39:20], pz[59:40], zero
    logic        s_axis_tlast = 1'b0;  // end_of_line
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // qx[19:0], qy[39:20], qz[59:40], zero
    logic [1:0]  m_axis_tuser;         // viable[0], truncated[1]
    logic        m_axis_tlast;         // last_out
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    polyline_arc_length_resample uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- model
    // Shadow copy of the vertex stores, running length and registers.
    longint unsigned vtx_mem [MAX_VTX][3];
    longint unsigned arc_mem [MAX_VTX];
    longint unsigned n_loaded;
    longint unsigned arc_run;
    longint unsigned r_step = 256;
    longint unsigned r_coarse = 0;
    longint unsigned r_mode = 0;
    longint unsigned r_final_len = 2560;
    longint unsigned r_group_len = 1024;
    longint unsigned r_min_count = 3;

    t_resample_pt pending_pts[$];   // resampled vertices still owed by the block

    int send_idle_pct = 38;
    int recv_idle_pct = 72;
    int err_count = 0;
    int n_vertices = 0;
    int n_results = 0;
    int n_runs = 0;
    int n_trunc_runs = 0;

    // rounded integer square root, as the segment length is measured
    function automatic longint unsigned seg_len(longint unsigned s);
        longint unsigned r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= s) r = t;
        end
        if (s - r * r > r) r++;
        return r;
    endfunction

    function automatic longint unsigned dist1(longint unsigned a, longint unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_resample_pt mk_pt(longint unsigned x, longint unsigned y,
                                           longint unsigned z, longint unsigned via,
                                           longint unsigned tr, bit last);
        t_resample_pt p;
        p.qx = x[19:0];
        p.qy = y[19:0];
        p.qz = z[19:0];
        p.viable = via[0];
        p.truncated = tr[0];
        p.last_out = last;
        return p;
    endfunction

    // Load one vertex; on an end mark resample the stored line into pts.
    task automatic resample_vertex(input logic [19:0] x, y, z, input logic eol,
                                   output t_resample_pt pts[$]);
        longint unsigned p[3];
        longint unsigned n, len, step, q, rem, size, m, j, via, tr, s, d;
        longint unsigned target, a0, a1, num, den, v0, v1, off;
        longint unsigned v[3];
        pts = {};
        p[0] = x; p[1] = y; p[2] = z;
        if (n_loaded < MAX_VTX) begin
            if (n_loaded > 0) begin
                s = 0;
                for (int c = 0; c < 3; c++) begin
                    d = dist1(p[c], vtx_mem[n_loaded-1][c]);
                    s += d * d;
                end
                arc_run += seg_len(s);
                if (arc_run > plar_pkg::LEN_MAX) arc_run = plar_pkg::LEN_MAX;
            end else begin
                arc_run = 0;
            end
            for (int c = 0; c < 3; c++) vtx_mem[n_loaded][c] = p[c];
            arc_mem[n_loaded] = arc_run;
            n_loaded++;
        end
        if (!eol) return;

        n = n_loaded;
        len = arc_run;
        n_loaded = 0;
        arc_run = 0;
        step = r_coarse ? 64 : r_step;
        if (step == 0) step = 1;
        if (n < 2 || len < step) begin
            pts = {pts, mk_pt(0, 0, 0, 0, 0, 1'b1)};
            return;
        end
        q = len / step;
        rem = len - q * step;
        if (2 * rem > step) q++;
        size = q + 1;
        tr = 0;
        if (size > MAX_VTX) begin
            size = MAX_VTX;
            tr = 1;
        end
        m = size - 1;
        if (r_mode == plar_pkg::MODE_COUNT) via = (size >= r_min_count);
        else if (r_mode == plar_pkg::MODE_GROUPING) via = (len > r_group_len);
        else via = (len > r_final_len);

        pts = {pts, mk_pt(vtx_mem[0][0], vtx_mem[0][1], vtx_mem[0][2], via, tr, 1'b0)};
        j = 1;
        for (longint unsigned i = 1; i < m; i++) begin
            target = len * i;
            // advance to the first stored vertex whose arc length reaches the target
            while (j < n - 1 && arc_mem[j] * m < target) j++;
            a0 = arc_mem[j-1];
            a1 = arc_mem[j];
            num = target - a0 * m;
            den = (a1 - a0) * m;
            if (den == 0) den = 1;
            for (int c = 0; c < 3; c++) begin
                v0 = vtx_mem[j-1][c];
                v1 = vtx_mem[j][c];
                off = (dist1(v1, v0) * num + den / 2) / den;
                v[c] = (v1 >= v0) ? v0 + off : v0 - off;
            end
            pts = {pts, mk_pt(v[0], v[1], v[2], via, tr, 1'b0)};
        end
        pts = {pts, mk_pt(vtx_mem[n-1][0], vtx_mem[n-1][1], vtx_mem[n-1][2],
                          via, tr, 1'b1)};
        n_runs++;
        if (tr) n_trunc_runs++;
    endtask

    // ------------------------------------------------------------- drivers
    // Offer one vertex item, hold it until taken, then queue what it owes.
    task automatic send_vertex(input logic [19:0] x, y, z, input logic eol,
                               input logic zero_run);
        t_resample_pt pts[$];
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, z, y, x};
        s_axis_tlast  <= eol;
        // sample the handshake mid-cycle, where both sides are settled
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        n_vertices++;
        resample_vertex(x, y, z, eol, pts);
        if (eol && zero_run) begin
            // a run too short to resample: one zero item, flagged last
            pts = {};
            pts = {pts, mk_pt(0, 0, 0, 0, 0, 1'b1)};
        end
        foreach (pts[k]) pending_pts = {pending_pts, pts[k]};
    endtask

    // Two-phase register write, then a read-back check once the bus is idle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] exp_val;
        case (idx)
            plar_pkg::REG_DESIRED_STEP: begin
                exp_val = val & 32'h1FFF;
                r_step  = exp_val;
            end
            plar_pkg::REG_COARSE_START: begin
                exp_val  = val & 32'h1;
                r_coarse = exp_val;
            end
            plar_pkg::REG_VIABILITY_MODE: begin
                exp_val = val & 32'h3;
                r_mode  = exp_val;
            end
            plar_pkg::REG_MIN_FINAL_LENGTH: begin
                exp_val     = val & 32'hFFFFF;
                r_final_len = exp_val;
            end
            plar_pkg::REG_GROUPING_LENGTH: begin
                exp_val     = val & 32'hFFFFF;
                r_group_len = exp_val;
            end
            plar_pkg::REG_MIN_VERTEX_COUNT: begin
                exp_val     = val & 32'h7F;
                r_min_count = exp_val;
            end
            default: exp_val = '0;
        endcase
        s_axis_tvalid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (prdata !== exp_val) begin
            $error("prdata: expected %h, got %h", exp_val, prdata);
            err_count++;
        end
    endtask

    // Let every owed item drain, then give the block time to go quiet.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic clamp_step(inout longint c, input int span);
        c = c + $signed($urandom_range(2 * span)) - span;
        if (c < 0) c = 0;
        if (c > FMAX) c = FMAX;
    endtask

    // One random polyline: mostly short well-formed lines around a random
    // base, now and then full-range jumps or a long line of 60 to 72 vertices
    // that can fill the store.
    task automatic send_random_line(output int sent);
        int nv, span, shape;
        longint cx, cy, cz;
        shape = $urandom_range(99);
        if (shape < 6) nv = $urandom_range(60, 72);
        else if (shape < 14) nv = 1;
        else nv = $urandom_range(2, 9);
        case ($urandom_range(3))
            0: span = 4;
            1: span = 300;
            2: span = 5000;
            default: span = 0;   // full-range jumps
        endcase
        cx = $urandom_range(FMAX);
        cy = $urandom_range(FMAX);
        cz = $urandom_range(FMAX);
        for (int k = 0; k < nv; k++) begin
            if (span == 0) begin
                cx = $urandom_range(FMAX);
                cy = $urandom_range(FMAX);
                cz = $urandom_range(FMAX);
            end else if (k > 0) begin
                clamp_step(cx, span);
                clamp_step(cy, span);
                clamp_step(cz, span);
            end
            send_vertex(cx[19:0], cy[19:0], cz[19:0], k == nv - 1, 1'b0);
        end
        sent = nv;
    endtask

    // ------------------------------------------------------------ receiver
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check results and run the watchdog at mid-cycle, where the handshake
    // that the coming edge completes is already settled.
    int quiet_cycles = 0;
    always @(negedge i_clk) begin
        t_resample_pt exp_pt;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_pts.size() == 0) begin
                $error("unexpected result item: tdata=%h tuser=%b tlast=%b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                err_count++;
            end else begin
                exp_pt = pending_pts.pop_front();
                if (m_axis_tdata[19:0] !== exp_pt.qx) begin
                    $error("qx: expected %h, got %h", exp_pt.qx, m_axis_tdata[19:0]);
                    err_count++;
                end
                if (m_axis_tdata[39:20] !== exp_pt.qy) begin
                    $error("qy: expected %h, got %h", exp_pt.qy, m_axis_tdata[39:20]);
                    err_count++;
                end
                if (m_axis_tdata[59:40] !== exp_pt.qz) begin
                    $error("qz: expected %h, got %h", exp_pt.qz, m_axis_tdata[59:40]);
                    err_count++;
                end
                if (m_axis_tuser[0] !== exp_pt.viable) begin
                    $error("viable: expected %b, got %b", exp_pt.viable, m_axis_tuser[0]);
                    err_count++;
                end
                if (m_axis_tuser[1] !== exp_pt.truncated) begin
                    $error("truncated: expected %b, got %b",
                           exp_pt.truncated, m_axis_tuser[1]);
                    err_count++;
                end
                if (m_axis_tlast !== exp_pt.last_out) begin
                    $error("last_out: expected %b, got %b", exp_pt.last_out, m_axis_tlast);
                    err_count++;
                end
            end
        end
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("watchdog: no item moved for %0d cycles, %0d results owed",
                     WDOG_MAX, pending_pts.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // -------------------------------------------------------------- stimulus
    t_vertex_row directed_rows[18] = '{
        '{20'h00005, 20'h00005, 20'h00005, 1'b1, 1'b1},  // lone vertex
        '{20'h00000, 20'h00000, 20'h00000, 1'b0, 1'b0},
        '{20'h00000, 20'h00000, 20'h00000, 1'b1, 1'b1},  // zero length line
        '{20'h00000, 20'h00000, 20'h00000, 1'b0, 1'b0},
        '{FMAX,      FMAX,      FMAX,      1'b1, 1'b0},  // full diagonal, saturates count
        '{FMAX,      20'h00000, FMAX,      1'b0, 1'b0},
        '{20'h00000, FMAX,      20'h00000, 1'b1, 1'b0},
        '{20'h00100, 20'h00100, 20'h00100, 1'b0, 1'b0},
        '{20'h00150, 20'h00100, 20'h00100, 1'b1, 1'b1},  // shorter than one step
        '{20'h01000, 20'h02000, 20'h03000, 1'b0, 1'b0},
        '{20'h01000, 20'h02000, 20'h03000, 1'b0, 1'b0},  // repeated vertex
        '{20'h01512, 20'h02000, 20'h03000, 1'b0, 1'b0},
        '{20'h01512, 20'h02512, 20'h03000, 1'b0, 1'b0},
        '{20'h01000, 20'h02512, 20'h02000, 1'b1, 1'b0},
        '{20'hAAAAA, 20'h55555, 20'hAAAAA, 1'b0, 1'b0},
        '{20'h55555, 20'hAAAAA, 20'h55555, 1'b1, 1'b0},
        '{20'h00800, 20'h00000, 20'h00000, 1'b0, 1'b0},
        '{20'h00000, 20'h00000, 20'h00000, 1'b1, 1'b0}   // falling coordinate
    };

    // register settings per phase: step, coarse, mode, final, grouping, count
    longint unsigned phase_cfg[7][6] = '{
        '{256,  0, 0, 2560,    1024,    3},
        '{16,   0, 1, 2560,    0,       2},
        '{4096, 0, 2, 1048575, 1024,    3},
        '{0,    1, 3, 0,       1024,    3},
        '{0,    0, 0, 2560,    1024,    64},
        '{8191, 0, 0, 2560,    1048575, 127},
        '{100,  0, 1, 0,       5000,    5}
    };

    initial begin
        int sent, phase_items;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows under the reset register values
        foreach (directed_rows[r])
            send_vertex(directed_rows[r].x, directed_rows[r].y, directed_rows[r].z,
                        directed_rows[r].eol, directed_rows[r].zero_run);

        for (int p = 0; p < 7; p++) begin
            drain_block();
            write_reg(plar_pkg::REG_DESIRED_STEP,     32'(phase_cfg[p][0]));
            write_reg(plar_pkg::REG_COARSE_START,     32'(phase_cfg[p][1]));
            write_reg(plar_pkg::REG_VIABILITY_MODE,   32'(phase_cfg[p][2]));
            write_reg(plar_pkg::REG_MIN_FINAL_LENGTH, 32'(phase_cfg[p][3]));
            write_reg(plar_pkg::REG_GROUPING_LENGTH,  32'(phase_cfg[p][4]));
            write_reg(plar_pkg::REG_MIN_VERTEX_COUNT, 32'(phase_cfg[p][5]));
            // swap the idle pressure between sides, then run without gaps
            if (p < 3) begin
                send_idle_pct = 38;
                recv_idle_pct = 72;
            end else if (p < 5) begin
                send_idle_pct = 72;
                recv_idle_pct = 38;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            phase_items = 0;
            while (phase_items < PHASE_VTX) begin
                send_random_line(sent);
                phase_items += sent;
            end
        end

        drain_block();
        $display("covered %0d vertices in %0d resampled lines (%0d truncated), %0d items checked",
                 n_vertices, n_runs, n_trunc_runs, n_results);
        $display("seven register settings incl. zero, coarse and maximum step and every mode");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: polyline_arc_length_resample.f
rtl/core/plar_pkg.sv
rtl/core/plar_ram.sv
rtl/core/plar_div.sv
rtl/core/plar_front.sv
rtl/core/plar_back.sv
rtl/core/polyline_arc_length_resample.sv
dv/tb_polyline_arc_length_resample.sv
